@@ rtl/core/lsbse_pkg.sv @@
// lsbse_pkg: shared types and constants for the LSB parity stego block.
// No dependencies; imported by every module under rtl/core but lsbse_checker.
`timescale 1ns / 1ps

package lsbse_pkg;

  // Header: two length bytes plus 32 tag-parity bytes
  localparam int unsigned HdrBytes = 34;
  localparam int unsigned PosW     = 17;
  localparam int unsigned LenW     = 16;
  localparam int unsigned TagW     = 32;

  localparam logic [TagW-1:0] TAG_WORD = 32'h7673_7467;  // "vstg"
  localparam logic [PosW-1:0] POS_MAX  = '1;
  localparam logic [7:0]      BYTE_MAX = 8'hFF;

  // Configuration register indexes
  typedef enum logic {
    REG_MODE     = 1'b0,
    REG_MSG_BITS = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    MODE_EMBED   = 1'b0,
    MODE_EXTRACT = 1'b1
  } mode_t;

  // One input item
  typedef struct packed {
    logic [7:0] cover_byte;
    logic       message_bit;
    logic       region_start;
  } item_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic [7:0] char_out;
    logic       char_valid;
    logic       tag_match;
    logic       region_done;
  } result_t;

endpackage

@@ rtl/core/lsbse_in_stage.sv @@
// lsbse_in_stage: input register for cover byte items.
// Depends on lsbse_pkg (item_t).
`timescale 1ns / 1ps

module lsbse_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  lsbse_pkg::item_t  in_item,
  input  logic              take,
  output logic              item_valid,
  output lsbse_pkg::item_t  item
);
  import lsbse_pkg::*;

  logic  valid_r;
  item_t item_r;

  // Hold while a registered item cannot move on
  assign in_stall   = valid_r && !take;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

@@ rtl/core/lsbse_core.sv @@
// lsbse_core: configuration registers, region sequencing state and the
// per-byte embed/extract logic. Depends on lsbse_pkg.
`timescale 1ns / 1ps

module lsbse_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               fire,
  input  lsbse_pkg::item_t   item,
  output lsbse_pkg::result_t result
);
  import lsbse_pkg::*;

  // Configuration
  mode_t           mode_r;
  logic [LenW-1:0] msg_bits_r;

  // Region state
  logic [PosW-1:0] position_r, position_nxt;
  logic [LenW-1:0] length_r,   length_nxt;
  logic [TagW-1:0] tag_r,      tag_nxt;
  logic [7:0]      char_r,     char_nxt;
  logic            tag_ok_r,   tag_ok_nxt;

  // State as seen by this item (region_start clears it first)
  logic [PosW-1:0] p;
  logic [LenW-1:0] len_base;
  logic [TagW-1:0] tag_base;
  logic [7:0]      char_base;
  logic            tag_ok_base;

  logic [PosW-1:0] end_emb;
  logic [LenW-1:0] total;
  logic [PosW-1:0] end_ext;
  logic [PosW-1:0] region_end;
  logic [4:0]      tag_idx;
  logic            par;
  logic            is_hdr;

  function automatic logic [7:0] set_parity(input logic [7:0] b, input logic bit_w);
    logic [7:0] r;
    r = b;
    if (b[0] != bit_w) begin
      r = (b == BYTE_MAX) ? 8'hFE : b + 8'd1;
    end
    return r;
  endfunction

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_EMBED;
      msg_bits_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:     mode_r     <= mode_t'(cfg_data[0]);
        REG_MSG_BITS: msg_bits_r <= cfg_data;
        default:      mode_r     <= mode_r;
      endcase
    end
  end

  assign p           = item.region_start ? '0 : position_r;
  assign len_base    = item.region_start ? '0 : length_r;
  assign tag_base    = item.region_start ? '0 : tag_r;
  assign char_base   = item.region_start ? '0 : char_r;
  assign tag_ok_base = item.region_start ? 1'b0 : tag_ok_r;

  assign end_emb = PosW'(HdrBytes) + {1'b0, msg_bits_r};
  assign total   = end_emb[LenW-1:0];
  assign par     = item.cover_byte[0];
  assign is_hdr  = (p < PosW'(HdrBytes));
  // Tag bit for positions 2..33, MSB first
  assign tag_idx = 5'(6'(HdrBytes - 1) - p[5:0]);

  // Per-byte datapath
  always_comb begin
    length_nxt = len_base;
    tag_nxt    = tag_base;
    char_nxt   = char_base;
    tag_ok_nxt = tag_ok_base;
    result     = '0;
    end_ext    = PosW'(HdrBytes);
    region_end = end_emb;
    result.out_byte = item.cover_byte;

    unique case (mode_r)
      MODE_EMBED: begin
        if (p == PosW'(0)) begin
          result.out_byte = total[15:8];
          length_nxt      = total;
        end else if (p == PosW'(1)) begin
          result.out_byte = total[7:0];
          length_nxt      = total;
        end else if (is_hdr) begin
          result.out_byte = set_parity(item.cover_byte, TAG_WORD[tag_idx]);
        end else if (p < end_emb) begin
          result.out_byte = set_parity(item.cover_byte, item.message_bit);
        end
        region_end = end_emb;
      end
      MODE_EXTRACT: begin
        if (p == PosW'(0)) begin
          length_nxt = {item.cover_byte, 8'h00};
          tag_ok_nxt = 1'b0;
        end else if (p == PosW'(1)) begin
          length_nxt = {len_base[15:8], item.cover_byte};
        end else if (is_hdr) begin
          tag_nxt = {tag_base[TagW-2:0], par};
          if (p == PosW'(HdrBytes - 1)) begin
            tag_ok_nxt = ({tag_base[TagW-2:0], par} == TAG_WORD);
          end
        end else if (tag_ok_base && (len_base >= LenW'(HdrBytes))
                     && (p < {1'b0, len_base})) begin
          char_nxt = {char_base[6:0], par};
          // Eighth message parity of a character
          if (p[2:0] == 3'd1) begin
            result.char_out   = {char_base[6:0], par};
            result.char_valid = 1'b1;
          end
        end
        result.tag_match = (p >= PosW'(HdrBytes - 1)) ? tag_ok_nxt : 1'b0;
        end_ext = (tag_ok_nxt && (length_nxt > LenW'(HdrBytes)))
                  ? {1'b0, length_nxt} : PosW'(HdrBytes);
        region_end = end_ext;
      end
      default: result.out_byte = item.cover_byte;
    endcase

    result.region_done = (({1'b0, p} + 18'd1) >= {1'b0, region_end});
    position_nxt = (p < POS_MAX) ? p + PosW'(1) : p;
  end

  // State update on each processed item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r <= '0;
      length_r   <= '0;
      tag_r      <= '0;
      char_r     <= '0;
      tag_ok_r   <= 1'b0;
    end else if (fire) begin
      position_r <= position_nxt;
      length_r   <= length_nxt;
      tag_r      <= tag_nxt;
      char_r     <= char_nxt;
      tag_ok_r   <= tag_ok_nxt;
    end
  end

endmodule

@@ rtl/core/lsbse_out_stage.sv @@
// lsbse_out_stage: result register toward the output channel.
// Depends on lsbse_pkg (result_t).
`timescale 1ns / 1ps

module lsbse_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  lsbse_pkg::result_t  res,
  output logic                take,
  output logic                out_valid,
  input  logic                out_stall,
  output lsbse_pkg::result_t  out_res
);
  import lsbse_pkg::*;

  logic    valid_r;
  result_t res_r;

  // Register can load when empty or being drained
  assign take      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_r <= res;
    end
  end

endmodule

@@ rtl/core/lsb_stego_embed_extract.sv @@
// LSB parity stego embed/extract, one cover byte per item.
// Path: input reg, then byte logic, then result reg; out_stall holds the result
// reg and, behind it, the input reg. Throughput: 1 item per cycle while
// out_stall is low; state update is a single pass of byte logic.
// Reset (rst_n low, synchronous): both channels empty, mode embed,
// message_bits 0, region state cleared. cfg_ready is always high.
`timescale 1ns / 1ps

module lsb_stego_embed_extract (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_cover_byte,
  input  logic        in_message_bit,
  input  logic        in_region_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [7:0]  out_char_out,
  output logic        out_char_valid,
  output logic        out_tag_match,
  output logic        out_region_done,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import lsbse_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    take;
  result_t res;
  result_t out_res;

  assign cfg_ready = 1'b1;

  assign in_item.cover_byte   = in_cover_byte;
  assign in_item.message_bit  = in_message_bit;
  assign in_item.region_start = in_region_start;

  lsbse_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  lsbse_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (item_valid && take),
    .item      (item),
    .result    (res)
  );

  lsbse_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (item_valid),
    .res       (res),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_byte        = out_res.out_byte;
  assign out_char_out    = out_res.char_out;
  assign out_char_valid  = out_res.char_valid;
  assign out_tag_match   = out_res.tag_match;
  assign out_region_done = out_res.region_done;

endmodule

@@ rtl/core/lsbse_checker.sv @@
// lsbse_checker: port-level assertions for lsb_stego_embed_extract.
// Sees only top-level ports; attached by the bind below.
`timescale 1ns / 1ps

module lsbse_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic [7:0] out_char_out,
  input logic       out_char_valid,
  input logic       out_tag_match
);

  // A stalled result holds its byte
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled result changed");

  // Input side backs up only behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // A character is only recovered behind a matching tag
  a_char_tag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_valid |-> out_tag_match)
    else $error("character without tag match");

  // No character value without char_valid
  a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_char_valid |-> out_char_out == 8'd0)
    else $error("char_out nonzero without char_valid");

endmodule

bind lsb_stego_embed_extract lsbse_checker u_lsbse_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .out_char_out   (out_char_out),
  .out_char_valid (out_char_valid),
  .out_tag_match  (out_tag_match)
);

@@ verif/lsb_stego_embed_extract_tb.sv @@
`timescale 1ns / 1ps
// lsb_stego_embed_extract_tb: self-checking bench for the LSB parity stego block.
// Streams cover-byte regions in embed and extract mode and checks every result
// item against an in-bench model. Depends on lsbse_pkg and the block RTL.

module lsb_stego_embed_extract_tb;
  import lsbse_pkg::*;

  localparam logic [31:0] TagVstg    = 32'h7673_7467;  // "vstg"
  localparam int unsigned HeaderLen  = 34;
  localparam int          StuckLimit = 2000;
  localparam int          HoldCycles = 150;

  // Shape of a generated extract region
  typedef enum int {
    HDR_GOOD,
    HDR_BAD_TAG,
    HDR_SHORT,
    HDR_MAX_LEN
  } region_kind_t;

  // Scoreboard: tracks region state and holds the result items still due
  class stego_scoreboard;
    mode_t       mode;
    logic [15:0] msg_bits;
    logic [16:0] pos;
    logic [15:0] len_word;
    logic [31:0] tag_sr;
    logic [7:0]  char_sr;
    logic        tag_ok;
    result_t     results_due[$];
    int          errors;

    function new();
      mode     = MODE_EMBED;
      msg_bits = '0;
      errors   = 0;
      clear_region();
    endfunction

    function void clear_region();
      pos      = '0;
      len_word = '0;
      tag_sr   = '0;
      char_sr  = '0;
      tag_ok   = 1'b0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [15:0] val);
      if (idx == REG_MODE) begin
        mode = mode_t'(val[0]);
      end else begin
        msg_bits = val;
      end
    endfunction

    // Bump the byte by one when its LSB disagrees; 0xFF steps down instead
    function logic [7:0] with_parity(logic [7:0] b, logic bit_want);
      if (b[0] == bit_want) return b;
      return (b == 8'hFF) ? 8'hFE : b + 8'd1;
    endfunction

    // Work out the result item of one accepted cover byte
    function void note_cover_byte(item_t it);
      result_t     r;
      int unsigned p;
      int unsigned stop;
      logic [15:0] total;
      if (it.region_start) clear_region();
      p = pos;
      r = '0;
      r.out_byte = it.cover_byte;
      if (mode == MODE_EMBED) begin
        total = 16'(HeaderLen + msg_bits);
        stop  = HeaderLen + msg_bits;
        if (p == 0) begin
          r.out_byte = total[15:8];
          len_word   = total;
        end else if (p == 1) begin
          r.out_byte = total[7:0];
          len_word   = total;
        end else if (p < HeaderLen) begin
          r.out_byte = with_parity(it.cover_byte, TagVstg[31 - (p - 2)]);
        end else if (p < stop) begin
          r.out_byte = with_parity(it.cover_byte, it.message_bit);
        end
        r.region_done = (p + 1 >= stop);
      end else begin
        if (p == 0) begin
          len_word = {it.cover_byte, 8'h00};
          tag_ok   = 1'b0;
        end else if (p == 1) begin
          len_word[7:0] = it.cover_byte;
        end else if (p < HeaderLen) begin
          tag_sr = {tag_sr[30:0], it.cover_byte[0]};
          if (p == HeaderLen - 1) tag_ok = (tag_sr == TagVstg);
        end else if (tag_ok && len_word >= HeaderLen && p < len_word) begin
          char_sr = {char_sr[6:0], it.cover_byte[0]};
          if (((p - HeaderLen) & 7) == 7) begin
            r.char_out   = char_sr;
            r.char_valid = 1'b1;
          end
        end
        r.tag_match   = (p >= HeaderLen - 1) ? tag_ok : 1'b0;
        stop          = (tag_ok && len_word > HeaderLen) ? len_word : HeaderLen;
        r.region_done = (p + 1 >= stop);
      end
      if (pos != '1) pos++;
      results_due.push_back(r);
    endfunction

    function void compare(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_stego_result(result_t got);
      result_t want;
      if (results_due.size() == 0) begin
        $display("%0t: result item with nothing due, actual %h", $time, got);
        errors++;
        return;
      end
      want = results_due.pop_front();
      compare("out_byte", want.out_byte, got.out_byte);
      compare("char_out", want.char_out, got.char_out);
      compare("char_valid", want.char_valid, got.char_valid);
      compare("tag_match", want.tag_match, got.tag_match);
      compare("region_done", want.region_done, got.region_done);
    endfunction
  endclass

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [7:0]  in_cover_byte   = '0;
  logic        in_message_bit  = 1'b0;
  logic        in_region_start = 1'b0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [7:0]  out_byte;
  logic [7:0]  out_char_out;
  logic        out_char_valid;
  logic        out_tag_match;
  logic        out_region_done;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  logic        cfg_index       = 1'b0;
  logic [15:0] cfg_data        = '0;

  stego_scoreboard sb;
  bit quiet       = 1'b0;
  int hold_req    = 0;
  int stall_left  = 0;
  int items_sent  = 0;
  int idle_cycles = 0;

  lsb_stego_embed_extract dut (.*);

  always #1 clk = ~clk;

  // Monitor: config writes, accepted items and results, in that order
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready === 1'b1) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_valid && in_stall === 1'b0)
        sb.note_cover_byte(item_t'{in_cover_byte, in_message_bit, in_region_start});
      if (out_valid === 1'b1 && !out_stall)
        sb.check_stego_result(result_t'{out_byte, out_char_out, out_char_valid,
                                        out_tag_match, out_region_done});
    end
  end

  // Watchdog: cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready === 1'b1) || (in_valid && in_stall === 1'b0) ||
        (out_valid === 1'b1 && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StuckLimit) begin
      $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
      $display("** lsb_stego_embed_extract: FAILED **");
      $finish;
    end
  end

  // Result side: random stall bursts, plus one long hold when asked
  always @(posedge clk) begin
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req   = 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 14);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  // Offer one item, with an optional gap before it, and wait until taken
  task automatic send_byte(input logic [7:0] b, input logic mb, input logic rs);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cover_byte   <= b;
    in_message_bit  <= mb;
    in_region_start <= rs;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  task automatic configure(input mode_t m, input logic [15:0] bits);
    cfg_valid <= 1'b1;
    cfg_index <= REG_MODE;
    cfg_data  <= {15'd0, m};
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_index <= REG_MSG_BITS;
    cfg_data  <= bits;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering and wait until every due result has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic noise(input int n);
    repeat (n) send_byte(rand_byte(), rand_bit(), $urandom_range(0, 11) == 0);
  endtask

  task automatic embed_region(input int n);
    send_byte(rand_byte(), rand_bit(), 1'b1);
    repeat (n - 1) send_byte(rand_byte(), rand_bit(), 1'b0);
  endtask

  // Region laid out as the embedder writes it: length, tag parities, message
  task automatic extract_region(input region_kind_t kind);
    int          n_msg;
    int          k;
    logic [15:0] hdr;
    logic [31:0] tag;
    n_msg = $urandom_range(0, 40);
    hdr   = 16'(HeaderLen + n_msg);
    tag   = TagVstg;
    case (kind)
      HDR_BAD_TAG: begin
        k      = $urandom_range(0, 31);
        tag[k] = ~tag[k];
      end
      HDR_SHORT:   hdr = 16'($urandom_range(0, 33));
      HDR_MAX_LEN: hdr = 16'hFFFF;
      default: ;
    endcase
    send_byte(hdr[15:8], rand_bit(), 1'b1);
    send_byte(hdr[7:0], rand_bit(), 1'b0);
    for (int i = 31; i >= 0; i--) begin
      send_byte((rand_byte() & 8'hFE) | {7'd0, tag[i]}, rand_bit(), 1'b0);
    end
    repeat (n_msg + $urandom_range(0, 4)) send_byte(rand_byte(), rand_bit(), 1'b0);
  endtask

  initial begin
    int           phase;
    int           extract_count;
    mode_t        m;
    logic [15:0]  bits;
    logic [7:0]   b;
    region_kind_t kind;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings, no region_start: first byte opens a region anyway.
    // Bytes cycle through 0xFF/0x00/0xFE/0x01 against both wanted parities.
    for (int i = 0; i < 24; i++) begin
      case (i % 4)
        0:       b = 8'hFF;
        1:       b = 8'h00;
        2:       b = 8'hFE;
        default: b = 8'h01;
      endcase
      send_byte(b, i[1], 1'b0);
    end
    drain();

    // Switch to extract in the middle of the tag; region carries on
    configure(MODE_EXTRACT, 16'hFFFF);
    repeat (14) send_byte(rand_byte(), rand_bit(), 1'b0);
    drain();

    // Random phases of embed and extract regions, some extract headers malformed, with some noise in between
    phase         = 0;
    extract_count = 0;
    while (items_sent < 420) begin
      m = (phase < 4) ? mode_t'(phase[0]) : mode_t'(rand_bit());
      if (phase == 0) begin
        bits = 16'd0;
      end else if (phase == 2 || $urandom_range(0, 9) == 0) begin
        bits = 16'd65501;
      end else begin
        bits = 16'($urandom_range(0, 40));
      end
      configure(m, bits);
      quiet = (items_sent >= 330) || ($urandom_range(0, 3) == 0);
      if (phase == 1) begin
        quiet    = 1'b0;
        hold_req = HoldCycles;
      end
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 5) == 0) noise($urandom_range(1, 10));
        if (m == MODE_EMBED) begin
          embed_region(HeaderLen + ((bits > 40) ? 40 : bits) + $urandom_range(0, 6));
        end else begin
          if (extract_count < 4) begin
            kind = region_kind_t'(extract_count);
          end else if ($urandom_range(0, 9) < 6) begin
            kind = HDR_GOOD;
          end else begin
            kind = region_kind_t'($urandom_range(1, 3));
          end
          extract_region(kind);
          extract_count++;
        end
      end
      drain();
      phase++;
    end
    repeat (8) @(posedge clk);

    if (sb.errors == 0 && sb.results_due.size() == 0) begin
      $display("** lsb_stego_embed_extract: PASSED **");
    end else begin
      $display("** lsb_stego_embed_extract: FAILED **");
    end
    $finish;
  end

endmodule
